### hdl/mrt_pkg.sv
package mrt_pkg;

  localparam int MAX_READINGS_DEF     = 64;
  localparam int SAMPLE_BITS_DEF      = 16;
  localparam int FACTOR_FRAC_BITS_DEF = 12;

  localparam int FACTOR_BITS = 16;
  localparam logic signed [FACTOR_BITS-1:0] FACTOR_RESET = 16'sd4096;

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;
  localparam logic REG_SCALE_FACTOR = 1'b0;

endpackage

### hdl/mrt_in_if.sv
interface mrt_in_if
  import mrt_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          set_end;

  modport source (output valid, output sample_value, output set_end, input ready);
  modport sink (input valid, input sample_value, input set_end, output ready);
endinterface

### hdl/mrt_out_if.sv
interface mrt_out_if;
  logic valid;
  logic ready;
  logic above_threshold;
  logic burst_end;

  modport source (output valid, output above_threshold, output burst_end, input ready);
  modport sink (input valid, input above_threshold, input burst_end, output ready);
endinterface

### hdl/mean_relative_threshold.sv
// Channel  Dir  Payload                         Accept
// in_ch    in   sample_value, set_end           valid && ready
// out_ch   out  above_threshold, burst_end      valid && ready
// APB      in   scale_factor at byte address 0  psel && penable && pwrite
//
// Loading accepts one reading per cycle; in_ch.ready is high only while loading.
// Closing a set first forms sum * factor on the shared multiplier; then
// each flag steps through store read, multiply, compare and present,
// holding while out_ch stalls; a set of n readings emits n flags.
// Synchronous active-high reset clears the sequencer, sum and count.
module mean_relative_threshold
  import mrt_pkg::*;
#(
  parameter int MAX_READINGS     = MAX_READINGS_DEF,
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
  parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  mrt_in_if.sink                   in_ch,
  mrt_out_if.source                out_ch
);

  localparam int CNT_BITS  = $clog2(MAX_READINGS + 1);
  localparam int IDX_BITS  = (MAX_READINGS > 1) ? $clog2(MAX_READINGS) : 1;
  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_READINGS);
  localparam int PROD_BITS = SUM_BITS + FACTOR_BITS;
  localparam int CMP_BITS  = PROD_BITS + FACTOR_FRAC_BITS;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_RHS   = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                    state;
  logic signed [SUM_BITS-1:0]    sum;
  logic [CNT_BITS-1:0]           count;
  logic [IDX_BITS-1:0]           idx;
  logic signed [PROD_BITS-1:0]   rhs;
  logic                          out_valid;
  logic                          above;
  logic                          last;

  logic signed [FACTOR_BITS-1:0] scale_factor;
  logic [SAMPLE_BITS-1:0]        rd_data;
  logic signed [SUM_BITS-1:0]    mul_a;
  logic signed [FACTOR_BITS-1:0] mul_b;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [CMP_BITS-1:0]    lhs_ext;
  logic signed [CMP_BITS-1:0]    rhs_ext;
  logic [CNT_BITS-1:0]           count_next;
  logic [CNT_BITS-1:0]           idx_plus;
  logic                          in_acc;
  logic                          close;
  logic                          is_last;

  mrt_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .scale_factor (scale_factor)
  );

  mrt_store #(
    .DEPTH     (MAX_READINGS),
    .WIDTH     (SAMPLE_BITS),
    .ADDR_BITS (IDX_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (count[IDX_BITS-1:0]),
    .wr_data (in_ch.sample_value),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  always_comb begin
    if (state == S_RHS) begin
      mul_a = sum;
      mul_b = scale_factor;
    end else begin
      mul_a = SUM_BITS'(signed'(rd_data));
      mul_b = signed'(FACTOR_BITS'(count));
    end
  end

  mrt_mul #(
    .A_BITS (SUM_BITS),
    .B_BITS (FACTOR_BITS)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign in_ch.ready = (state == S_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign count_next  = count + CNT_BITS'(1);
  assign close       = in_ch.set_end || (count_next == CNT_BITS'(MAX_READINGS));
  assign idx_plus    = CNT_BITS'(idx) + CNT_BITS'(1);
  assign is_last     = (idx_plus == count);

  assign lhs_ext = CMP_BITS'(prod) <<< FACTOR_FRAC_BITS;
  assign rhs_ext = CMP_BITS'(rhs);

  assign out_ch.valid           = out_valid;
  assign out_ch.above_threshold = above;
  assign out_ch.burst_end       = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      sum       <= '0;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            sum   <= sum + SUM_BITS'(in_ch.sample_value);
            count <= count_next;
            if (close) begin
              state <= S_RHS;
            end
          end
        end
        S_RHS: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          if (idx == '0) begin
            rhs <= prod;
          end
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_CMP;
        end
        S_CMP: begin
          above     <= (lhs_ext > rhs_ext);
          last      <= is_last;
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_valid <= 1'b0;
            if (last) begin
              sum   <= '0;
              count <= '0;
              idx   <= '0;
              state <= S_LOAD;
            end else begin
              idx   <= idx + IDX_BITS'(1);
              state <= S_FETCH;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

### hdl/mrt_cfg.sv
module mrt_cfg
  import mrt_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_BITS-1:0]      paddr,
  input  logic [APB_DATA_BITS-1:0]      pwdata,
  output logic [APB_DATA_BITS-1:0]      prdata,
  output logic                          pready,
  output logic signed [FACTOR_BITS-1:0] scale_factor
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == REG_SCALE_FACTOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= FACTOR_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      scale_factor <= signed'(pwdata[FACTOR_BITS-1:0]);
    end
  end

  assign prdata = hit ? APB_DATA_BITS'(scale_factor) : '0;

endmodule

### hdl/mrt_store.sv
module mrt_store #(
  parameter int DEPTH    = 64,
  parameter int WIDTH    = 16,
  parameter int ADDR_BITS = 6
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/mrt_mul.sv
module mrt_mul #(
  parameter int A_BITS = 22,
  parameter int B_BITS = 16
) (
  input  logic                              clk,
  input  logic signed [A_BITS-1:0]          a,
  input  logic signed [B_BITS-1:0]          b,
  output logic signed [A_BITS+B_BITS-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
